// ===== hdl/whpa_pkg.sv =====
// ----------------------------------------------------------------------------
// whpa_pkg
// shared types, constants and the weight lookup of the weighted hamming
// pair accumulator
// ----------------------------------------------------------------------------
package whpa_pkg;

	localparam int STATE_BITS     = 5;
	localparam int NUM_STATES     = 16;
	localparam int WEIGHT_BITS    = 16;
	localparam int FRAC_BITS      = WEIGHT_BITS - 4;
	localparam int LANE_BITS      = 16;
	localparam int LANES_PER_REG  = 4;
	localparam int NUM_WEIGHT_REGS = 4;
	localparam int CFG_DATA_BITS  = LANE_BITS * LANES_PER_REG;
	localparam int ACC_BITS       = 42;
	localparam int PROD_BITS      = 2 * WEIGHT_BITS;
	localparam int REG_INDEX_BITS = 3;

	localparam logic [STATE_BITS-1:0] MISSING_STATE = STATE_BITS'(2);
	localparam logic [CFG_DATA_BITS-1:0] WEIGHT_REG_RESET = 64'h1000_1000_1000_1000;
	localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

	typedef logic [STATE_BITS-1:0]  state_t;
	typedef logic [WEIGHT_BITS-1:0] weight_t;
	typedef logic [ACC_BITS-1:0]    acc_t;
	typedef logic [NUM_WEIGHT_REGS-1:0][CFG_DATA_BITS-1:0] weight_bank_t;

	// configuration register indexes
	typedef enum logic [REG_INDEX_BITS-1:0] {
		REG_MISSING_MODE  = 3'd0,
		REG_WEIGHTS_1_4   = 3'd1,
		REG_WEIGHTS_5_8   = 3'd2,
		REG_WEIGHTS_9_12  = 3'd3,
		REG_WEIGHTS_13_16 = 3'd4
	} reg_index_t;

	// one locus held in the input stage
	typedef struct packed {
		state_t state_a;
		state_t state_b;
		logic   last_locus;
	} locus_t;

	// states outside 1..NUM_STATES carry weight zero
	function automatic weight_t weight_of(input state_t st, input weight_bank_t bank);
		logic [3:0]           idx;
		logic [LANE_BITS-1:0] lane;
		idx  = 4'(st - STATE_BITS'(1));
		lane = bank[idx[3:2]][{idx[1:0], 4'b0000} +: LANE_BITS];
		if (st < STATE_BITS'(1) || st > STATE_BITS'(NUM_STATES)) begin
			return '0;
		end
		return lane[WEIGHT_BITS-1:0];
	endfunction

endpackage

// ===== hdl/whpa_locus_if.sv =====
// ----------------------------------------------------------------------------
// whpa_locus_if
// valid/ready channel carrying one locus of a row pair
// ----------------------------------------------------------------------------
interface whpa_locus_if;
	import whpa_pkg::*;

	logic   valid;
	logic   ready;
	state_t state_a;
	state_t state_b;
	logic   last_locus;

	modport source (output valid, output state_a, output state_b, output last_locus,
		input ready);
	modport sink (input valid, input state_a, input state_b, input last_locus,
		output ready);
endinterface

// ===== hdl/whpa_result_if.sv =====
// ----------------------------------------------------------------------------
// whpa_result_if
// valid/ready channel carrying the distance of one row pair
// ----------------------------------------------------------------------------
interface whpa_result_if;
	import whpa_pkg::*;

	logic valid;
	logic ready;
	acc_t distance;
	logic saturated;

	modport source (output valid, output distance, output saturated, input ready);
	modport sink (input valid, input distance, input saturated, output ready);
endinterface

// ===== hdl/whpa_addend_gen.sv =====
// ----------------------------------------------------------------------------
// whpa_addend_gen
// weight lookup, weight product and missing-run tracking for one locus;
// yields the value to be added to the accumulator
// ----------------------------------------------------------------------------
module whpa_addend_gen (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  whpa_pkg::locus_t       locus,
	input  logic                   missing_mode,
	input  whpa_pkg::weight_bank_t weights,
	output whpa_pkg::acc_t         addend
);
	import whpa_pkg::*;

	logic    run_a_q, run_b_q;
	weight_t w_a, w_b, w_miss;
	logic [PROD_BITS-1:0] product;
	logic    a_miss, b_miss, differ;
	acc_t    penalty;

	assign w_a     = weight_of(locus.state_a, weights);
	assign w_b     = weight_of(locus.state_b, weights);
	assign w_miss  = weight_of(MISSING_STATE, weights);
	assign product = PROD_BITS'(w_a) * PROD_BITS'(w_b);
	assign penalty = ACC_BITS'(w_miss) << FRAC_BITS;
	assign a_miss  = (locus.state_a == MISSING_STATE);
	assign b_miss  = (locus.state_b == MISSING_STATE);
	assign differ  = (locus.state_a != locus.state_b);

	// at most one addition per locus: the two run starts exclude each other
	// and exclude the product
	always_comb begin
		addend = '0;
		if (missing_mode) begin
			if (a_miss && !b_miss && !run_a_q) begin
				addend = penalty;
			end else if (b_miss && !a_miss && !run_b_q) begin
				addend = penalty;
			end else if (differ && !a_miss && !b_miss) begin
				addend = ACC_BITS'(product);
			end
		end else if (differ) begin
			addend = ACC_BITS'(product);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_a_q <= 1'b0;
			run_b_q <= 1'b0;
		end else if (advance) begin
			if (locus.last_locus) begin
				run_a_q <= 1'b0;
				run_b_q <= 1'b0;
			end else if (missing_mode) begin
				run_a_q <= a_miss && (run_a_q || !b_miss);
				run_b_q <= b_miss && (run_b_q || !a_miss);
			end
		end
	end

endmodule

// ===== hdl/weighted_hamming_pair_accumulator.sv =====
// ----------------------------------------------------------------------------
// weighted_hamming_pair_accumulator
// weighted hamming distance between two character-state rows, one locus
// per transaction, with optional missing-state handling
// ----------------------------------------------------------------------------
// One locus is accepted every clock cycle while input ready is high. A locus
// passes an input register, a stage that looks up both Q4.12 weights and
// multiplies them (16x16), and a saturating 42-bit add into the accumulator;
// a row pair's result enters the output register as its last locus leaves the
// product register. The only stall comes from the output register: loci keep
// flowing while a result waits, and input ready drops only when a second last
// locus reaches the accumulator while the previous result is still not taken.
// Weights and the missing mode must be written through the configuration port
// between row pairs, while no transaction is in flight; the block won't check.
// ----------------------------------------------------------------------------
module weighted_hamming_pair_accumulator (
	input  logic                                    clk,
	input  logic                                    arst_n,
	whpa_locus_if.sink                              loci,
	whpa_result_if.source                           result,
	input  logic                                    cfg_we,
	input  logic [whpa_pkg::REG_INDEX_BITS-1:0]     cfg_index,
	input  logic [whpa_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
	import whpa_pkg::*;

	// configuration registers
	logic         missing_mode_q;
	weight_bank_t weights_q;

	// pipeline
	logic   valid_s1, valid_s2;
	locus_t locus_s1;
	logic   last_s2;
	acc_t   addend, addend_s2;
	logic   stall;

	// accumulator and result register
	acc_t   acc_q;
	logic   ovf_q;
	logic [ACC_BITS:0] sum;
	acc_t   acc_next;
	logic   clamp;
	logic   out_valid_q;
	acc_t   distance_q;
	logic   saturated_q;

	// configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			missing_mode_q <= 1'b0;
			weights_q      <= {NUM_WEIGHT_REGS{WEIGHT_REG_RESET}};
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_MISSING_MODE:  missing_mode_q <= cfg_data[0];
				REG_WEIGHTS_1_4:   weights_q[0]   <= cfg_data;
				REG_WEIGHTS_5_8:   weights_q[1]   <= cfg_data;
				REG_WEIGHTS_9_12:  weights_q[2]   <= cfg_data;
				REG_WEIGHTS_13_16: weights_q[3]   <= cfg_data;
				default: ;
			endcase
		end
	end

	// a last locus cannot leave the accumulator while an untaken result sits
	// in the output register, and then every stage holds
	assign stall      = valid_s2 && last_s2 && out_valid_q && !result.ready;
	assign loci.ready = !stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= loci.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && loci.valid) begin
			locus_s1.state_a    <= loci.state_a;
			locus_s1.state_b    <= loci.state_b;
			locus_s1.last_locus <= loci.last_locus;
		end
	end

	// weight product, missing penalty and run flags
	whpa_addend_gen u_addend_gen (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (valid_s1 && !stall),
		.locus        (locus_s1),
		.missing_mode (missing_mode_q),
		.weights      (weights_q),
		.addend       (addend)
	);

	// product register ahead of the add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && valid_s1) begin
			addend_s2 <= addend;
			last_s2   <= locus_s1.last_locus;
		end
	end

	// saturating accumulate
	assign sum      = {1'b0, acc_q} + {1'b0, addend_s2};
	assign clamp    = sum[ACC_BITS];
	assign acc_next = clamp ? ACC_MAX : sum[ACC_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
		end else if (valid_s2 && !stall) begin
			if (last_s2) begin
				// row pair done, start the next one from zero
				acc_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				acc_q <= acc_next;
				ovf_q <= ovf_q || clamp;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s2 && last_s2 && !stall) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && last_s2 && !stall) begin
			distance_q  <= acc_next;
			saturated_q <= ovf_q || clamp;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.distance  = distance_q;
	assign result.saturated = saturated_q;

	// input only backs up behind a held result
	assert property (@(posedge clk) disable iff (!arst_n)
		!loci.ready |-> (out_valid_q && !result.ready))
		else $error("input stalled without a held result");

	// the accumulator restarts from zero after a row pair
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && last_s2 && !stall) |=> (acc_q == '0 && !ovf_q))
		else $error("accumulator not cleared after last locus");

	// once clamped the sum stays at full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (acc_q == ACC_MAX))
		else $error("overflow flag without a full-scale accumulator");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && saturated_q) |-> (distance_q == ACC_MAX))
		else $error("saturated result below full scale");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// regression bench for the weighted hamming pair accumulator
// ----------------------------------------------------------------------------
// Streams loci of row pairs into the block and checks every distance that
// comes back against a cycle-free model of the accumulation. The model tracks
// the weight bank, the missing mode, the missing-run flags and saturation.
// Directed tests cover the reset weights, the extremes of the weights and
// states, missing runs, a mode switch inside a pair and saturation. Random
// phases follow, each with its own configuration. Both sides idle at random
// except in the fourth and the last phase.
// ----------------------------------------------------------------------------
module tb;
	import whpa_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int SETTLE_CYCLES = 10;     // pipeline is three deep, some margin
	localparam int CYCLE_LIMIT   = 300000;
	localparam int MAX_REPORTS   = 10;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_LOCI    = 16;
	localparam int SAT_LOCI      = 1030;   // enough max products to pass 2^42

	typedef struct packed {
		acc_t distance;
		logic saturated;
	} pair_result_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [REG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	whpa_locus_if  loci_ch ();
	whpa_result_if result_ch ();

	weighted_hamming_pair_accumulator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.loci      (loci_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// model of the block: configuration copy and accumulation state
	logic         model_missing_mode;
	weight_bank_t model_bank;
	acc_t         model_acc;
	logic         model_run_a;
	logic         model_run_b;
	logic         model_overflow;

	// distances predicted but not yet seen on the result channel
	pair_result_t pending_distances[$];

	bit idling_enabled;
	int error_count;
	int loci_sent;
	int pairs_checked;
	int saturated_pairs;
	int cfg_writes;
	int cycle_count;

	// generator state for random missing runs
	bit gen_run_a;
	bit gen_run_b;

	// ------------------------------------------------------------------------
	// clock and watchdog
	// ------------------------------------------------------------------------
	always begin
		clk = 1'b1;
		#CLK_HALF;
		clk = 1'b0;
		#CLK_HALF;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d distances still pending",
				cycle_count, pending_distances.size());
			$display("weighted_hamming_pair_accumulator regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// model
	// ------------------------------------------------------------------------

	// states outside 1..NUM_STATES weigh nothing
	function automatic weight_t lookup_weight(input state_t st);
		logic [3:0] idx;
		idx = 4'(st - state_t'(1));
		if (st == state_t'(0) || st > state_t'(NUM_STATES)) begin
			return '0;
		end
		return model_bank[idx[3:2]][idx[1:0]*LANE_BITS +: WEIGHT_BITS];
	endfunction

	// add with clamp at the top of the 42-bit range
	function automatic void add_clamped(input acc_t amount);
		logic [ACC_BITS:0] sum;
		sum = {1'b0, model_acc} + {1'b0, amount};
		if (sum[ACC_BITS]) begin
			model_acc      = ACC_MAX;
			model_overflow = 1'b1;
		end else begin
			model_acc = sum[ACC_BITS-1:0];
		end
	endfunction

	// one accepted locus; a last locus queues the distance of the pair
	function automatic void accumulate_locus(input state_t a, input state_t b,
		input logic last);
		logic  a_miss;
		logic  b_miss;
		acc_t  penalty;
		acc_t  product;
		a_miss  = (a == MISSING_STATE);
		b_miss  = (b == MISSING_STATE);
		penalty = acc_t'(lookup_weight(MISSING_STATE)) << FRAC_BITS;
		product = acc_t'(lookup_weight(a)) * acc_t'(lookup_weight(b));
		if (model_missing_mode) begin
			// a missing run costs the state-2 weight once, at its first locus
			if (!model_run_a && a_miss && !b_miss) begin
				model_run_a = 1'b1;
				add_clamped(penalty);
			end
			if (!model_run_b && b_miss && !a_miss) begin
				model_run_b = 1'b1;
				add_clamped(penalty);
			end
			if (model_run_a && !a_miss) begin
				model_run_a = 1'b0;
			end
			if (model_run_b && !b_miss) begin
				model_run_b = 1'b0;
			end
			if (a != b && !a_miss && !b_miss) begin
				add_clamped(product);
			end
		end else if (a != b) begin
			// plain mode leaves the run flags alone
			add_clamped(product);
		end
		if (last) begin
			pending_distances.push_back('{distance: model_acc, saturated: model_overflow});
			model_acc      = '0;
			model_run_a    = 1'b0;
			model_run_b    = 1'b0;
			model_overflow = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------------
	// result side: random back-pressure and the distance check
	// ------------------------------------------------------------------------
	initial begin
		int           stall_left;
		pair_result_t want;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				if (pending_distances.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS) begin
						$display("[%0t] distance %h with no pair pending", $realtime,
							result_ch.distance);
					end
				end else begin
					want = pending_distances.pop_front();
					pairs_checked++;
					if (result_ch.saturated) begin
						saturated_pairs++;
					end
					if (result_ch.distance !== want.distance) begin
						error_count++;
						if (error_count <= MAX_REPORTS) begin
							$display("[%0t] distance: expected %h, got %h", $realtime,
								want.distance, result_ch.distance);
						end
					end
					if (result_ch.saturated !== want.saturated) begin
						error_count++;
						if (error_count <= MAX_REPORTS) begin
							$display("[%0t] saturated: expected %b, got %b", $realtime,
								want.saturated, result_ch.saturated);
						end
					end
				end
			end
			// ready drops in random stall bursts
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (idling_enabled && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 5);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// locus side
	// ------------------------------------------------------------------------

	// one locus transaction; valid stays up for the next call
	task automatic send_locus(input state_t a, input state_t b, input logic last);
		int gap;
		if (idling_enabled && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			loci_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		loci_ch.valid      <= 1'b1;
		loci_ch.state_a    <= a;
		loci_ch.state_b    <= b;
		loci_ch.last_locus <= last;
		@(posedge clk);
		while (!loci_ch.ready) @(posedge clk);
		loci_sent++;
		accumulate_locus(a, b, last);
	endtask

	// hold the sender until every distance is back and the pipe is empty
	task automatic settle();
		loci_ch.valid <= 1'b0;
		while (pending_distances.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// program the registers back to back; only while the block is idle
	task automatic write_regs(input logic mode, input weight_bank_t bank,
		input bit mode_only);
		reg_index_t               order[5];
		logic [CFG_DATA_BITS-1:0] data;
		order = '{REG_MISSING_MODE, REG_WEIGHTS_1_4, REG_WEIGHTS_5_8,
			REG_WEIGHTS_9_12, REG_WEIGHTS_13_16};
		foreach (order[k]) begin
			if (mode_only && order[k] != REG_MISSING_MODE) begin
				continue;
			end
			if (order[k] == REG_MISSING_MODE) begin
				// upper bits are don't-care, toggle them anyway
				data    = {$urandom, $urandom};
				data[0] = mode;
			end else begin
				data = bank[order[k] - REG_WEIGHTS_1_4];
			end
			cfg_we    <= 1'b1;
			cfg_index <= order[k];
			cfg_data  <= data;
			@(posedge clk);
			cfg_writes++;
		end
		cfg_we <= 1'b0;
		model_missing_mode = mode;
		if (!mode_only) begin
			model_bank = bank;
		end
	endtask

	// style 0 all max, 1 all zero, otherwise mixed lanes with extremes
	function automatic weight_bank_t pick_bank(input int style);
		weight_bank_t bank;
		int           roll;
		for (int r = 0; r < NUM_WEIGHT_REGS; r++) begin
			for (int l = 0; l < LANES_PER_REG; l++) begin
				roll = $urandom_range(0, 7);
				if (style == 0 || (style > 1 && roll == 0)) begin
					bank[r][l*LANE_BITS +: LANE_BITS] = '1;
				end else if (style == 1 || roll == 1) begin
					bank[r][l*LANE_BITS +: LANE_BITS] = '0;
				end else begin
					bank[r][l*LANE_BITS +: LANE_BITS] = LANE_BITS'($urandom);
				end
			end
		end
		return bank;
	endfunction

	// random state for one row, with runs of the missing state
	function automatic state_t pick_state(inout bit in_run);
		int roll;
		roll = $urandom_range(0, 99);
		in_run = in_run ? (roll < 65) : (roll < 15);
		if (in_run) begin
			return MISSING_STATE;
		end
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			return state_t'($urandom_range(0, 31));
		end
		return state_t'($urandom_range(1, NUM_STATES));
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// weights left at 1.0 after reset, plain mode
	task automatic test_reset_weights();
		send_locus(5'd1, 5'd3, 1'b1);
		send_locus(5'd4, 5'd4, 1'b1);
		send_locus(5'd16, 5'd15, 1'b0);
		send_locus(5'd2, 5'd9, 1'b0);
		send_locus(5'd7, 5'd7, 1'b1);
		settle();
	endtask

	// all-max and all-zero weights, out-of-range states
	task automatic test_weight_extremes();
		weight_bank_t bank;
		write_regs(1'b0, pick_bank(0), 1'b0);
		send_locus(5'd0, 5'd31, 1'b0);     // both weightless but different
		send_locus(5'd31, 5'd31, 1'b0);
		send_locus(5'd16, 5'd1, 1'b0);
		send_locus(5'd17, 5'd16, 1'b0);
		send_locus(5'd1, 5'd16, 1'b1);
		settle();
		write_regs(1'b0, pick_bank(1), 1'b0);
		send_locus(5'd1, 5'd16, 1'b0);
		send_locus(5'd0, 5'd0, 1'b1);
		settle();
		// distinct weights per state, lane order checked
		for (int r = 0; r < NUM_WEIGHT_REGS; r++) begin
			for (int l = 0; l < LANES_PER_REG; l++) begin
				bank[r][l*LANE_BITS +: LANE_BITS] = LANE_BITS'(16'h0100 * (4*r + l + 1) + 16'h0011);
			end
		end
		write_regs(1'b0, bank, 1'b0);
		send_locus(5'd4, 5'd13, 1'b0);
		send_locus(5'd8, 5'd9, 1'b0);
		send_locus(5'd12, 5'd5, 1'b1);
		settle();
	endtask

	// missing runs in either row, both missing, run still open at the end
	task automatic test_missing_runs();
		write_regs(1'b1, pick_bank(2), 1'b0);
		send_locus(5'd2, 5'd5, 1'b0);      // run in a starts
		send_locus(5'd2, 5'd6, 1'b0);
		send_locus(5'd2, 5'd2, 1'b0);      // both missing: nothing added
		send_locus(5'd3, 5'd8, 1'b0);      // run in a ends
		send_locus(5'd2, 5'd8, 1'b0);      // new run in a
		send_locus(5'd9, 5'd2, 1'b0);      // a ends, b starts
		send_locus(5'd9, 5'd2, 1'b0);
		send_locus(5'd2, 5'd2, 1'b0);
		send_locus(5'd11, 5'd2, 1'b1);     // b run open at last locus
		send_locus(5'd4, 5'd2, 1'b0);      // cleared, so this run counts again
		send_locus(5'd0, 5'd31, 1'b1);
		settle();
	endtask

	// the mode changes between loci of one pair, with the pipe drained
	task automatic test_mode_switch_mid_pair();
		write_regs(1'b1, pick_bank(2), 1'b0);
		send_locus(5'd2, 5'd4, 1'b0);
		send_locus(5'd2, 5'd4, 1'b0);
		settle();
		write_regs(1'b0, model_bank, 1'b1);
		send_locus(5'd2, 5'd4, 1'b0);      // plain: state 2 is an ordinary state
		send_locus(5'd5, 5'd2, 1'b0);
		settle();
		write_regs(1'b1, model_bank, 1'b1);
		send_locus(5'd2, 5'd7, 1'b0);      // run flag of a survived plain mode
		send_locus(5'd3, 5'd3, 1'b1);
		settle();
	endtask

	// long pair of max products clamps, the next pair starts clean
	task automatic test_saturation();
		write_regs(1'b0, pick_bank(0), 1'b0);
		for (int i = 0; i < SAT_LOCI; i++) begin
			send_locus(5'd1, 5'd3, 1'b0);
		end
		send_locus(5'd1, 5'd3, 1'b1);
		send_locus(5'd16, 5'd15, 1'b1);
		settle();
	endtask

	// random phases, each with its own setup; fourth and last without idling
	task automatic test_random_pairs();
		int     phase_loci;
		int     pair_len;
		logic   mode;
		state_t a;
		state_t b;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			idling_enabled = (phase != RANDOM_PHASES - 1) && (phase != 3);
			mode = (phase < 4) ? logic'(phase % 2) : logic'($urandom_range(0, 1));
			write_regs(mode, pick_bank(phase < 2 ? phase : $urandom_range(0, 7)), 1'b0);
			gen_run_a  = 0;
			gen_run_b  = 0;
			phase_loci = 0;
			while (phase_loci < PHASE_LOCI) begin
				pair_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
					: $urandom_range(1, 12);
				for (int i = 0; i < pair_len; i++) begin
					a = pick_state(gen_run_a);
					b = pick_state(gen_run_b);
					if ($urandom_range(0, 3) == 0) begin
						b = a;
					end
					send_locus(a, b, logic'(i == pair_len - 1));
				end
				phase_loci += pair_len;
			end
			settle();
		end
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		error_count        = 0;
		loci_sent          = 0;
		pairs_checked      = 0;
		saturated_pairs    = 0;
		cfg_writes         = 0;
		cycle_count        = 0;
		idling_enabled     = 1;
		model_missing_mode = 1'b0;
		model_bank         = {NUM_WEIGHT_REGS{WEIGHT_REG_RESET}};
		model_acc          = '0;
		model_run_a        = 1'b0;
		model_run_b        = 1'b0;
		model_overflow     = 1'b0;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= REG_MISSING_MODE;
		cfg_data           <= '0;
		loci_ch.valid      <= 1'b0;
		loci_ch.state_a    <= '0;
		loci_ch.state_b    <= '0;
		loci_ch.last_locus <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_weights();
		test_weight_extremes();
		test_missing_runs();
		test_mode_switch_mid_pair();
		test_saturation();
		test_random_pairs();
		settle();

		$display("%0d loci in %0d row pairs checked, %0d of them saturated",
			loci_sent, pairs_checked, saturated_pairs);
		$display("%0d register writes, %0d mismatches", cfg_writes, error_count);
		if (error_count == 0 && pending_distances.size() == 0) begin
			$display("weighted_hamming_pair_accumulator regression: pass");
		end else begin
			$display("weighted_hamming_pair_accumulator regression: fail");
		end
		$finish;
	end

endmodule
